FILE: design/idt_pkg.sv
`default_nettype none

package idt_pkg;

	// default number of indent levels, base level included
	localparam int unsigned STACK_DEPTH_DEF = 64;

	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned KIND_W  = 2;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_NEWLINE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INDENT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DEDENT  = 2'd2;

	typedef logic [LEVEL_W-1:0] level_t;

	// shift command broadcast to every stack cell
	typedef struct packed {
		logic   push;
		logic   pop;
		level_t data;
	} stack_op_t;

endpackage

`default_nettype wire

FILE: design/idt_req_if.sv
`default_nettype none

interface idt_req_if;
	logic                  valid;
	logic                  ready;
	logic                  at_end_now;
	logic                  saw_line_break;
	idt_pkg::level_t       line_indent;
	logic                  at_end_after_gap;
	logic                  accept_newline;
	logic                  accept_indent;
	logic                  accept_dedent;

	modport source (
		output valid, at_end_now, saw_line_break, line_indent, at_end_after_gap,
		       accept_newline, accept_indent, accept_dedent,
		input  ready
	);
	modport sink (
		input  valid, at_end_now, saw_line_break, line_indent, at_end_after_gap,
		       accept_newline, accept_indent, accept_dedent,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/idt_tok_if.sv
`default_nettype none

interface idt_tok_if;
	logic                          valid;
	logic                          ready;
	logic                          token_found;
	logic [idt_pkg::KIND_W-1:0]    token_kind;
	logic                          stack_overflow;

	modport source (
		output valid, token_found, token_kind, stack_overflow,
		input  ready
	);
	modport sink (
		input  valid, token_found, token_kind, stack_overflow,
		output ready
	);
endinterface

`default_nettype wire

FILE: design/idt_cell.sv
`default_nettype none

// one stack entry: takes the shallower neighbor on push, the deeper one on pop
module idt_cell (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  idt_pkg::stack_op_t op,
	input  idt_pkg::level_t    from_above,
	input  idt_pkg::level_t    from_below,
	output idt_pkg::level_t    level
);

	idt_pkg::level_t level_q;

	// shift along the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (op.push) begin
			level_q <= from_above;
		end else if (op.pop) begin
			level_q <= from_below;
		end
	end

	assign level = level_q;

endmodule

`default_nettype wire

FILE: design/idt_ctrl.sv
`default_nettype none

// token decision, level count, unwind state and output word register
module idt_ctrl #(
	parameter int unsigned STACK_DEPTH = idt_pkg::STACK_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	idt_req_if.sink            req,
	idt_tok_if.source          tok,
	input  idt_pkg::level_t    top_level,
	output idt_pkg::stack_op_t op
);

	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

	logic [CNT_W-1:0]            count_q;
	logic                        unwinding_q;
	idt_pkg::level_t             target_q;
	logic                        tok_valid_q;
	logic                        found_q;
	logic [idt_pkg::KIND_W-1:0]  kind_q;
	logic                        ovf_q;

	logic                        accept;
	logic                        can_pop;
	logic                        found_d;
	logic [idt_pkg::KIND_W-1:0]  kind_d;
	logic                        ovf_d;
	logic                        push_d;
	logic                        pop_d;
	logic                        unwinding_d;
	idt_pkg::level_t             target_d;

	// output register frees the input side whenever it drains
	assign req.ready = !tok_valid_q || tok.ready;
	assign accept    = req.valid && req.ready;
	assign can_pop   = count_q > CNT_ONE;

	// token decision against the cached top level
	always_comb begin
		found_d     = 1'b0;
		kind_d      = idt_pkg::KIND_NEWLINE;
		ovf_d       = 1'b0;
		push_d      = 1'b0;
		pop_d       = 1'b0;
		unwinding_d = unwinding_q;
		target_d    = target_q;
		if (unwinding_q) begin
			if (target_q < top_level && req.accept_dedent) begin
				pop_d   = can_pop;
				found_d = 1'b1;
				kind_d  = idt_pkg::KIND_DEDENT;
			end else begin
				unwinding_d = 1'b0;
				found_d     = target_q == top_level && req.accept_newline;
			end
		end else if (req.at_end_now) begin
			if (req.accept_dedent && can_pop) begin
				pop_d   = 1'b1;
				found_d = 1'b1;
				kind_d  = idt_pkg::KIND_DEDENT;
			end
		end else if (!req.saw_line_break) begin
			found_d = 1'b0;
		end else if (req.at_end_after_gap) begin
			if (req.accept_dedent && can_pop) begin
				pop_d   = 1'b1;
				found_d = 1'b1;
				kind_d  = idt_pkg::KIND_DEDENT;
			end else begin
				found_d = req.accept_newline;
			end
		end else if (req.line_indent > top_level && req.accept_indent) begin
			found_d = 1'b1;
			kind_d  = idt_pkg::KIND_INDENT;
			push_d  = count_q < CNT_FULL;
			ovf_d   = !(count_q < CNT_FULL);
		end else if (req.line_indent < top_level && req.accept_dedent) begin
			found_d     = 1'b1;
			kind_d      = idt_pkg::KIND_DEDENT;
			pop_d       = can_pop;
			unwinding_d = 1'b1;
			target_d    = req.line_indent;
		end else begin
			found_d = req.accept_newline;
		end
	end

	assign op.push = accept && push_d;
	assign op.pop  = accept && pop_d;
	assign op.data = req.line_indent;

	// level count and unwind state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_ONE;
			unwinding_q <= 1'b0;
			target_q    <= '0;
		end else if (accept) begin
			unwinding_q <= unwinding_d;
			target_q    <= target_d;
			if (push_d) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop_d) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (req.ready) begin
			tok_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_q <= found_d;
			kind_q  <= found_d ? kind_d : idt_pkg::KIND_NEWLINE;
			ovf_q   <= ovf_d;
		end
	end

	assign tok.valid          = tok_valid_q;
	assign tok.token_found    = found_q;
	assign tok.token_kind     = kind_q;
	assign tok.stack_overflow = ovf_q;

endmodule

`default_nettype wire

FILE: design/indent_dedent_token_scanner.sv
// Indentation token scanner.
// req channel: one word per token request (end-of-input flags, line break seen,
// indent of the next line, and which of NEWLINE / INDENT / DEDENT the parser takes).
// tok channel: one word per request: token_found, token_kind (0 newline,
// 1 indent, 2 dedent) and stack_overflow when an indent push was dropped.
// The result word is registered at the accept edge.
// Throughput is one request per cycle unless tok stalls; the decision needs
// only the top level, which always sits in the first cell of the level chain,
// and one push or pop shifts every cell by one place in the same cycle.
// STACK_DEPTH cells hold the open levels, base level 0 included; a push onto a
// full chain is dropped and flagged, the INDENT is still reported.
// Reset leaves one open level (0), no unwinding and an empty output register.
// When the tok receiver stalls, the held word stays put and req.ready drops
// until it is taken; with the output register free a request is taken at once.
`default_nettype none

module indent_dedent_token_scanner #(
	parameter int unsigned STACK_DEPTH = idt_pkg::STACK_DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	idt_req_if.sink   req,
	idt_tok_if.source tok
);

	idt_pkg::stack_op_t op;
	idt_pkg::level_t    levels [STACK_DEPTH];

	// decision and control
	idt_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.tok       (tok),
		.top_level (levels[0]),
		.op        (op)
	);

	// level chain, top of stack in cell 0
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		idt_pkg::level_t above;
		idt_pkg::level_t below;
		if (i == 0) begin : g_first
			assign above = op.data;
		end else begin : g_mid_above
			assign above = levels[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_mid_below
			assign below = levels[i+1];
		end
		idt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.from_above (above),
			.from_below (below),
			.level      (levels[i])
		);
	end

endmodule

`default_nettype wire

FILE: design/idt_checker.sv
`default_nettype none

module idt_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic                       tok_valid,
	input wire logic                       tok_ready,
	input wire logic                       token_found,
	input wire logic [idt_pkg::KIND_W-1:0] token_kind,
	input wire logic                       stack_overflow
);

	// every accepted request yields a word in the next cycle
	a_req_to_tok: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> tok_valid)
		else $error("no token word after accepted request");

	// a dropped push is only reported on an indent
	a_ovf_indent: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && stack_overflow |-> token_found && token_kind == idt_pkg::KIND_INDENT)
		else $error("overflow without indent token");

	// no token means a cleared kind and no overflow
	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !token_found |-> token_kind == idt_pkg::KIND_NEWLINE && !stack_overflow)
		else $error("stray kind or overflow without token");

	// stalled word holds
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(token_found)
			&& $stable(token_kind) && $stable(stack_overflow))
		else $error("token word changed while stalled");

endmodule

bind indent_dedent_token_scanner idt_checker u_idt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.tok_valid      (tok.valid),
	.tok_ready      (tok.ready),
	.token_found    (tok.token_found),
	.token_kind     (tok.token_kind),
	.stack_overflow (tok.stack_overflow)
);

`default_nettype wire

FILE: tb/tb_indent_dedent_token_scanner.sv
`timescale 1ns / 1ps

module tb_indent_dedent_token_scanner;

	localparam int unsigned STACK_DEPTH = idt_pkg::STACK_DEPTH_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 480;
	localparam int CLIMB_LEN   = 70;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_LEN    = 120;
	localparam int SHOW_MAX    = 10;

	// copies of the scanner state: one checks the block, one steers the generator
	localparam int CHECK  = 0;
	localparam int SHADOW = 1;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct packed {
		logic            at_end_now;
		logic            saw_line_break;
		idt_pkg::level_t line_indent;
		logic            at_end_after_gap;
		logic            acc_nl;
		logic            acc_in;
		logic            acc_de;
	} scan_req_t;

	typedef struct packed {
		logic                       found;
		logic [idt_pkg::KIND_W-1:0] kind;
		logic                       overflow;
	} scan_tok_t;

	typedef struct packed {
		scan_req_t  w;
		idle_mode_t mode;
		logic       drain;
	} queued_req_t;

	logic clk;
	logic arst_n;

	idt_req_if req();
	idt_tok_if tok();

	indent_dedent_token_scanner #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.tok(tok)
	);

	// indent level stacks and unwind state, per copy
	idt_pkg::level_t open_levels [2][STACK_DEPTH];
	int unsigned     open_count [2];
	idt_pkg::level_t unwind_goal [2];
	bit              unwind_on [2];

	queued_req_t pending_reqs[$];
	scan_tok_t   tok_expect[$];

	int unsigned total_reqs;
	int unsigned req_taken;
	int unsigned tok_taken;
	int unsigned mismatches;
	int unsigned n_newline, n_indent, n_dedent, n_silent, n_overflow;
	idle_mode_t  cur_mode;

	// driver locals
	int unsigned sent_n;
	queued_req_t nxt;
	bit          go;

	// receiver locals
	int unsigned rx_seen;
	int          hold_left;
	bit          hold_done;
	bit          stall;

	// monitor locals
	scan_req_t   seen_req;
	scan_tok_t   got_tok;
	scan_tok_t   exp_tok;

	int unsigned quiet_cycles;

	function automatic void clear_levels(int s);
		open_levels[s][0] = '0;
		open_count[s] = 1;
		unwind_goal[s] = '0;
		unwind_on[s] = 1'b0;
	endfunction

	function automatic idt_pkg::level_t top_of(int s);
		return open_levels[s][open_count[s]-1];
	endfunction

	// one token decision; pops never go below the base level
	function automatic scan_tok_t scan_token(int s, scan_req_t w);
		scan_tok_t       r;
		idt_pkg::level_t top;
		r = '0;
		top = top_of(s);
		if (unwind_on[s]) begin
			if (unwind_goal[s] < top && w.acc_de) begin
				if (open_count[s] > 1) open_count[s]--;
				r.found = 1'b1;
				r.kind = idt_pkg::KIND_DEDENT;
			end else begin
				unwind_on[s] = 1'b0;
				if (unwind_goal[s] == top && w.acc_nl) begin
					r.found = 1'b1;
					r.kind = idt_pkg::KIND_NEWLINE;
				end
			end
		end else if (w.at_end_now) begin
			if (w.acc_de && open_count[s] > 1) begin
				open_count[s]--;
				r.found = 1'b1;
				r.kind = idt_pkg::KIND_DEDENT;
			end
		end else if (!w.saw_line_break) begin
			r = '0;
		end else if (w.at_end_after_gap) begin
			if (w.acc_de && open_count[s] > 1) begin
				open_count[s]--;
				r.found = 1'b1;
				r.kind = idt_pkg::KIND_DEDENT;
			end else if (w.acc_nl) begin
				r.found = 1'b1;
				r.kind = idt_pkg::KIND_NEWLINE;
			end
		end else if (w.line_indent > top && w.acc_in) begin
			r.found = 1'b1;
			r.kind = idt_pkg::KIND_INDENT;
			if (open_count[s] < STACK_DEPTH) begin
				open_levels[s][open_count[s]] = w.line_indent;
				open_count[s]++;
			end else begin
				r.overflow = 1'b1;
			end
		end else if (w.line_indent < top && w.acc_de) begin
			unwind_goal[s] = w.line_indent;
			unwind_on[s] = 1'b1;
			if (open_count[s] > 1) open_count[s]--;
			r.found = 1'b1;
			r.kind = idt_pkg::KIND_DEDENT;
		end else if (w.acc_nl) begin
			r.found = 1'b1;
			r.kind = idt_pkg::KIND_NEWLINE;
		end
		return r;
	endfunction

	function automatic scan_req_t make_req(bit ae, bit lb, int ind, bit aeg,
			bit acc_n, bit acc_i, bit acc_d);
		scan_req_t w;
		w.at_end_now = ae;
		w.saw_line_break = lb;
		w.line_indent = idt_pkg::level_t'(ind);
		w.at_end_after_gap = aeg;
		w.acc_nl = acc_n;
		w.acc_in = acc_i;
		w.acc_de = acc_d;
		return w;
	endfunction

	task automatic enqueue(scan_req_t w, idle_mode_t m, bit drain);
		queued_req_t q;
		q.w = w;
		q.mode = m;
		q.drain = drain;
		pending_reqs.push_back(q);
		void'(scan_token(SHADOW, w));
		total_reqs++;
	endtask

	// random request stream shaped like source text: indents, dedents, eof runs
	task automatic gen_phase(int n, idle_mode_t m, bit climb_now);
		int        useful;
		int        cat;
		int        top;
		int        ind;
		int        climb_left;
		int        eof_left;
		bit        first;
		bit        quiet;
		scan_req_t w;
		useful = 0;
		climb_left = climb_now ? CLIMB_LEN : 0;
		eof_left = 0;
		first = 1'b1;
		while (useful < n) begin
			top = top_of(SHADOW);
			quiet = 1'b0;
			w = '0;
			w.acc_nl = ($urandom_range(9) != 0);
			w.acc_in = ($urandom_range(9) != 0);
			w.acc_de = ($urandom_range(9) != 0);
			if (!unwind_on[SHADOW] && eof_left == 0 && climb_left == 0 &&
					$urandom_range(149) == 0)
				climb_left = CLIMB_LEN;
			if (unwind_on[SHADOW]) begin
				// everything but the accept flags is ignored here
				w.at_end_now = $urandom_range(1);
				w.saw_line_break = $urandom_range(1);
				w.at_end_after_gap = $urandom_range(1);
				w.line_indent = idt_pkg::level_t'($urandom);
			end else if (eof_left > 0) begin
				eof_left--;
				w.at_end_now = 1'b1;
				w.saw_line_break = $urandom_range(1);
				w.line_indent = idt_pkg::level_t'($urandom);
			end else if (climb_left > 0) begin
				climb_left--;
				w.saw_line_break = 1'b1;
				w.acc_in = 1'b1;
				ind = top + $urandom_range(4, 1);
				w.line_indent = idt_pkg::level_t'((ind > 65535) ? 65535 : ind);
			end else begin
				cat = $urandom_range(99);
				if (cat < 8) begin
					w = scan_req_t'($urandom);
				end else if (cat < 14) begin
					w = scan_req_t'($urandom);
					w.at_end_now = 1'b0;
					w.saw_line_break = 1'b0;
					quiet = 1'b1;
				end else if (cat < 18) begin
					eof_left = $urandom_range(open_count[SHADOW], 0);
					w.at_end_now = 1'b1;
				end else if (cat < 25) begin
					w.saw_line_break = 1'b1;
					w.at_end_after_gap = 1'b1;
					w.line_indent = idt_pkg::level_t'($urandom);
				end else if (cat < 52) begin
					w.saw_line_break = 1'b1;
					if ($urandom_range(19) == 0)
						ind = $urandom_range(65535, top);
					else
						ind = top + $urandom_range(8, 1);
					w.line_indent = idt_pkg::level_t'((ind > 65535) ? 65535 : ind);
				end else if (cat < 72 || top == 0) begin
					w.saw_line_break = 1'b1;
					w.line_indent = idt_pkg::level_t'(top);
				end else if (cat < 94) begin
					w.saw_line_break = 1'b1;
					if ($urandom_range(9) < 3 || open_count[SHADOW] < 2)
						w.line_indent = idt_pkg::level_t'($urandom_range(top - 1, 0));
					else
						w.line_indent =
							open_levels[SHADOW][$urandom_range(open_count[SHADOW] - 2, 0)];
				end else begin
					w.saw_line_break = 1'b1;
					w.line_indent = idt_pkg::level_t'($urandom);
				end
			end
			enqueue(w, m, first || ($urandom_range(99) == 0));
			first = 1'b0;
			if (!quiet) useful++;
		end
	endtask

	task automatic note_bad(string why, scan_tok_t e, scan_tok_t g);
		mismatches++;
		if (mismatches <= SHOW_MAX)
			$display("%0t: %s: expected found=%0b kind=%0d ovf=%0b, got found=%0b kind=%0d ovf=%0b",
				$realtime, why, e.found, e.kind, e.overflow, g.found, g.kind, g.overflow);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// reset, stimulus build and end of run
	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.at_end_now = 1'b0;
		req.saw_line_break = 1'b0;
		req.line_indent = '0;
		req.at_end_after_gap = 1'b0;
		req.accept_newline = 1'b0;
		req.accept_indent = 1'b0;
		req.accept_dedent = 1'b0;
		tok.ready = 1'b0;
		cur_mode = IDLE_NONE;
		total_reqs = 0;
		mismatches = 0;
		clear_levels(CHECK);
		clear_levels(SHADOW);

		// directed: base level, eof at base, refused tokens, max indent, unwinding
		enqueue(make_req(0, 0, 0, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 0, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(1, 0, 0, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 0, 1, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 0, 1, 0, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 4, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 8, 0, 1, 0, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 8, 0, 0, 0, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 8, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 65535, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 2, 0, 1, 1, 0), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 2, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(1, 0, 65535, 1, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 0, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 0, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 4, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 8, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 4, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 4, 0, 1, 1, 0), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 12, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 0, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 0, 0, 0, 1, 0), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 0, 1, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(0, 1, 16, 0, 1, 1, 1), IDLE_NONE, 1'b0);
		enqueue(make_req(1, 0, 0, 0, 1, 1, 0), IDLE_NONE, 1'b0);
		enqueue(make_req(1, 0, 0, 0, 1, 1, 1), IDLE_NONE, 1'b0);

		// random phases; the first opens with a climb past a full stack
		gen_phase(PHASE_ITEMS, IDLE_NONE, 1'b1);
		gen_phase(PHASE_ITEMS, IDLE_SEND, 1'b0);
		gen_phase(PHASE_ITEMS, IDLE_RECV, 1'b0);
		gen_phase(PHASE_ITEMS, IDLE_BOTH, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (tok_taken != total_reqs) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tok_expect.size() != 0) begin
			$display("%0d expected tokens never arrived", tok_expect.size());
			mismatches += tok_expect.size();
		end
		$display("%0d requests: %0d newline, %0d indent, %0d dedent, %0d silent",
			req_taken, n_newline, n_indent, n_dedent, n_silent);
		$display("%0d dropped pushes on a full stack, %0d mismatches", n_overflow, mismatches);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			sent_n = 0;
		end else begin
			if (req.valid && req.ready) sent_n = sent_n + 1;
			if (!req.valid || req.ready) begin
				go = (pending_reqs.size() != 0);
				// a drain word waits until every token so far has been taken
				if (go && pending_reqs[0].drain && sent_n != tok_taken) go = 1'b0;
				if (go && pending_reqs[0].mode == IDLE_SEND) go = ($urandom_range(99) >= 77);
				if (go && pending_reqs[0].mode == IDLE_BOTH) go = ($urandom_range(99) >= 10);
				if (go) begin
					nxt = pending_reqs.pop_front();
					req.at_end_now <= nxt.w.at_end_now;
					req.saw_line_break <= nxt.w.saw_line_break;
					req.line_indent <= nxt.w.line_indent;
					req.at_end_after_gap <= nxt.w.at_end_after_gap;
					req.accept_newline <= nxt.w.acc_nl;
					req.accept_indent <= nxt.w.acc_in;
					req.accept_dedent <= nxt.w.acc_de;
					cur_mode <= nxt.mode;
					req.valid <= 1'b1;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// token receiver with one long hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			tok.ready <= 1'b0;
			rx_seen = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (tok.valid && tok.ready) rx_seen = rx_seen + 1;
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				tok.ready <= 1'b0;
			end else if (!hold_done && rx_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
				tok.ready <= 1'b0;
			end else begin
				case (cur_mode)
					IDLE_RECV: stall = ($urandom_range(99) < 77);
					IDLE_BOTH: stall = ($urandom_range(99) < 10);
					default:   stall = 1'b0;
				endcase
				tok.ready <= !stall;
			end
		end
	end

	// predict on each accepted request word, check each token word
	always @(posedge clk) begin
		if (!arst_n) begin
			req_taken <= 0;
			tok_taken <= 0;
			n_newline = 0;
			n_indent = 0;
			n_dedent = 0;
			n_silent = 0;
			n_overflow = 0;
		end else begin
			if (req.valid && req.ready) begin
				seen_req.at_end_now = req.at_end_now;
				seen_req.saw_line_break = req.saw_line_break;
				seen_req.line_indent = req.line_indent;
				seen_req.at_end_after_gap = req.at_end_after_gap;
				seen_req.acc_nl = req.accept_newline;
				seen_req.acc_in = req.accept_indent;
				seen_req.acc_de = req.accept_dedent;
				tok_expect.push_back(scan_token(CHECK, seen_req));
				req_taken <= req_taken + 1;
			end
			if (tok.valid && tok.ready) begin
				got_tok.found = tok.token_found;
				got_tok.kind = tok.token_kind;
				got_tok.overflow = tok.stack_overflow;
				tok_taken <= tok_taken + 1;
				if (!got_tok.found) n_silent++;
				else if (got_tok.kind == idt_pkg::KIND_NEWLINE) n_newline++;
				else if (got_tok.kind == idt_pkg::KIND_INDENT) n_indent++;
				else n_dedent++;
				if (got_tok.overflow) n_overflow++;
				if (tok_expect.size() == 0) begin
					note_bad("token with nothing pending", '0, got_tok);
				end else begin
					exp_tok = tok_expect.pop_front();
					if (got_tok.found !== exp_tok.found || got_tok.kind !== exp_tok.kind ||
							got_tok.overflow !== exp_tok.overflow)
						note_bad("token mismatch", exp_tok, got_tok);
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req.valid && req.ready) || (tok.valid && tok.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout after %0d cycles with no word moving", quiet_cycles);
			$display("FAILED: results differ");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
